### src/nonpreemptive_priority_scheduler_top_macros.svh
// Assertion macros for the priority scheduler block.
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH

`ifndef SYNTH
`define NPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define NPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NPS_ASSERT_IMP(lbl, ante, cons, msg)
`define NPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### src/nps_pkg.sv
// Shared constants and controller/datapath interface types for the scheduler.
package nps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int ARR_W  = 16;
  localparam int PRI_W  = 8;
  localparam int BUR_W  = 16;
  localparam int TIME_W = 21;
  localparam int JOB_W  = 5;

  typedef struct packed {
    logic             load_job;
    logic             scan_start;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             decide;
    logic             first;
    logic             calc_tat;
    logic             emit;
    logic             last;
    logic             finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] job_count;
    logic             out_busy;
  } dp_sts_t;

endpackage

### src/nps_ctrl.sv
// Sequencer for job loading, ready-set scans and result issue.
`include "nonpreemptive_priority_scheduler_top_macros.svh"

module nps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_job,
  output logic              in_stall,
  input  nps_pkg::dp_sts_t  sts,
  output nps_pkg::ctl_cmd_t cmd
);
  import nps_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_TAT,
    ST_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             first_r, first_nxt;
  logic             scan_end;
  logic             k_end;

  assign in_stall = (state_r != ST_IDLE);
  assign scan_end = (CNT_W'(scan_r) + CNT_W'(1)) == sts.job_count;
  assign k_end    = (CNT_W'(k_r) + CNT_W'(1)) == sts.job_count;

  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    k_nxt     = k_r;
    first_nxt = first_r;
    cmd       = '0;
    cmd.rd_addr = scan_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_job = 1'b1;
          if (in_last_job) begin
            first_nxt = 1'b1;
            scan_nxt  = '0;
            k_nxt     = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en      = 1'b1;
        cmd.scan_start = (scan_r == '0);
        if (scan_end) begin
          scan_nxt  = '0;
          state_nxt = ST_DRAIN;
        end else begin
          scan_nxt = scan_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        cmd.first  = first_r;
        first_nxt  = 1'b0;
        state_nxt  = ST_TAT;
      end
      ST_TAT: begin
        cmd.calc_tat = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          cmd.last = k_end;
          if (k_end) begin
            cmd.finish = 1'b1;
            k_nxt      = '0;
            state_nxt  = ST_IDLE;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = ST_SCAN;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      scan_r  <= '0;
      k_r     <= '0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
      k_r     <= k_nxt;
      first_r <= first_nxt;
    end
  end

  `NPS_ASSERT_IMP(a_scan_bound, cmd.rd_en, CNT_W'(cmd.rd_addr) < sts.job_count, "scan past set")
  `NPS_ASSERT_IMP(a_k_bound, state_r == ST_EMIT, CNT_W'(k_r) < sts.job_count, "too many results")
  `NPS_ASSERT_NXT(a_first_once, state_r == ST_DECIDE, !first_r, "first pick flag held")

endmodule

### src/nps_datapath.sv
// Job stores, selection accumulators, time arithmetic and result register.
`include "nonpreemptive_priority_scheduler_top_macros.svh"

module nps_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nps_pkg::ctl_cmd_t            cmd,
  output nps_pkg::dp_sts_t             sts,
  input  logic [nps_pkg::ARR_W-1:0]    in_arrival_time,
  input  logic [nps_pkg::PRI_W-1:0]    in_priority_req,
  input  logic [nps_pkg::BUR_W-1:0]    in_burst_time,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [nps_pkg::JOB_W-1:0]    out_job_number,
  output logic [nps_pkg::TIME_W-1:0]   out_completion_time,
  output logic [nps_pkg::TIME_W-1:0]   out_turnaround_time,
  output logic [nps_pkg::TIME_W-1:0]   out_waiting_time,
  output logic                         out_last_result
);
  import nps_pkg::*;

  logic [ARR_W-1:0] arr_mem [MAX_PROCS];
  logic [PRI_W-1:0] pri_mem [MAX_PROCS];
  logic [BUR_W-1:0] bur_mem [MAX_PROCS];

  logic [CNT_W-1:0]     job_cnt_r;
  logic [MAX_PROCS-1:0] done_r;
  logic                 full;

  logic             eval_r;
  logic [IDX_W-1:0] eval_idx_r;
  logic [ARR_W-1:0] rd_arr_r;
  logic [PRI_W-1:0] rd_pri_r;
  logic [BUR_W-1:0] rd_bur_r;

  logic             min_vld_r;
  logic [ARR_W-1:0] min_arr_r;
  logic [IDX_W-1:0] p2_idx_r;
  logic [PRI_W-1:0] p2_pri_r;
  logic [BUR_W-1:0] p2_bur_r;

  logic             have_r;
  logic [IDX_W-1:0] rp_idx_r;
  logic [PRI_W-1:0] rp_pri_r;
  logic [ARR_W-1:0] rp_arr_r;
  logic [BUR_W-1:0] rp_bur_r;

  logic [TIME_W-1:0] ct_r;
  logic [TIME_W-1:0] tat_r;
  logic [IDX_W-1:0]  sel_idx_r;
  logic [ARR_W-1:0]  sel_arr_r;
  logic [BUR_W-1:0]  sel_bur_r;

  logic              undone;
  logic              ready;
  logic              use_ready;
  logic [IDX_W-1:0]  pick_idx;
  logic [ARR_W-1:0]  pick_arr;
  logic [BUR_W-1:0]  pick_bur;
  logic [TIME_W-1:0] base_time;

  logic              out_valid_r;
  logic [JOB_W-1:0]  out_job_r;
  logic [TIME_W-1:0] out_ct_r;
  logic [TIME_W-1:0] out_tat_r;
  logic [TIME_W-1:0] out_wt_r;
  logic              out_last_r;

  assign full   = (job_cnt_r == CNT_W'(MAX_PROCS));
  assign undone = ~done_r[eval_idx_r];
  assign ready  = undone && (TIME_W'(rd_arr_r) <= ct_r);

  assign use_ready = have_r && !cmd.first;
  assign pick_idx  = use_ready ? rp_idx_r : p2_idx_r;
  assign pick_arr  = use_ready ? rp_arr_r : min_arr_r;
  assign pick_bur  = use_ready ? rp_bur_r : p2_bur_r;
  assign base_time = use_ready ? ct_r : TIME_W'(min_arr_r);

  assign sts.job_count = job_cnt_r;
  assign sts.out_busy  = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load_job && !full) begin
      arr_mem[job_cnt_r[IDX_W-1:0]] <= in_arrival_time;
      pri_mem[job_cnt_r[IDX_W-1:0]] <= in_priority_req;
      bur_mem[job_cnt_r[IDX_W-1:0]] <= in_burst_time;
    end
    if (cmd.rd_en) begin
      rd_arr_r <= arr_mem[cmd.rd_addr];
      rd_pri_r <= pri_mem[cmd.rd_addr];
      rd_bur_r <= bur_mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_cnt_r   <= '0;
      done_r      <= '0;
      eval_r      <= 1'b0;
      min_vld_r   <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      eval_r <= cmd.rd_en;
      if (cmd.finish) begin
        job_cnt_r <= '0;
        done_r    <= '0;
      end else begin
        if (cmd.load_job && !full) begin
          job_cnt_r <= job_cnt_r + CNT_W'(1);
        end
        if (cmd.decide) begin
          done_r[pick_idx] <= 1'b1;
        end
      end
      if (cmd.scan_start) begin
        min_vld_r <= 1'b0;
        have_r    <= 1'b0;
      end else if (eval_r) begin
        if (undone) begin
          min_vld_r <= 1'b1;
        end
        if (ready) begin
          have_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r <= cmd.rd_addr;
    if (eval_r && !cmd.scan_start) begin
      if (undone) begin
        priority if (!min_vld_r || rd_arr_r < min_arr_r) begin
          min_arr_r <= rd_arr_r;
          p2_idx_r  <= eval_idx_r;
          p2_pri_r  <= rd_pri_r;
          p2_bur_r  <= rd_bur_r;
        end else if (rd_arr_r == min_arr_r && rd_pri_r > p2_pri_r) begin
          p2_idx_r <= eval_idx_r;
          p2_pri_r <= rd_pri_r;
          p2_bur_r <= rd_bur_r;
        end else begin
          min_arr_r <= min_arr_r;
        end
      end
      if (ready && (!have_r || rd_pri_r > rp_pri_r ||
                    (rd_pri_r == rp_pri_r && rd_arr_r < rp_arr_r))) begin
        rp_idx_r <= eval_idx_r;
        rp_pri_r <= rd_pri_r;
        rp_arr_r <= rd_arr_r;
        rp_bur_r <= rd_bur_r;
      end
    end
    if (cmd.decide) begin
      ct_r      <= base_time + TIME_W'(pick_bur);
      sel_idx_r <= pick_idx;
      sel_arr_r <= pick_arr;
      sel_bur_r <= pick_bur;
    end
    if (cmd.calc_tat) begin
      tat_r <= ct_r - TIME_W'(sel_arr_r);
    end
    if (cmd.emit) begin
      out_job_r  <= JOB_W'(sel_idx_r) + JOB_W'(1);
      out_ct_r   <= ct_r;
      out_tat_r  <= tat_r;
      out_wt_r   <= tat_r - TIME_W'(sel_bur_r);
      out_last_r <= cmd.last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_job_number      = out_job_r;
  assign out_completion_time = out_ct_r;
  assign out_turnaround_time = out_tat_r;
  assign out_waiting_time    = out_wt_r;
  assign out_last_result     = out_last_r;

  `NPS_ASSERT_IMP(a_emit_slot, cmd.emit, !(out_valid_r && out_stall), "result overwritten")
  `NPS_ASSERT_IMP(a_pick_found, cmd.decide, min_vld_r, "no unfinished job at decision")
  `NPS_ASSERT_NXT(a_done_clear, cmd.finish, done_r == '0 && job_cnt_r == '0, "set not cleared")

endmodule

### src/nonpreemptive_priority_scheduler_top.sv
// Top level of the non-preemptive priority scheduler.
//
// Input channel: one job per request (arrival, priority, burst, last_job).
// Jobs are taken one per cycle while the block is idle; in_stall is high
// whenever a set is being scheduled. Up to MAX_PROCS jobs are kept, and
// further jobs of the same set are dropped. The job with last_job closes
// the set and starts scheduling.
// Result channel: one request per job in execution order, carrying the
// job number, completion, turnaround and waiting times; last_result marks
// the final job of the set.
// Each result comes from a scan of the job store, one read per cycle
// through its single registered port, then a drain state, the pick, the
// turnaround and the result register.
// A stalled receiver holds the result register; the scan of the next job
// does not start until the register frees and the result is issued.
// Reset clears the job count, done flags and both handshakes; job stores
// are not cleared and need no sweep.
module nonpreemptive_priority_scheduler_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [nps_pkg::ARR_W-1:0]   in_arrival_time,
  input  logic [nps_pkg::PRI_W-1:0]   in_priority_req,
  input  logic [nps_pkg::BUR_W-1:0]   in_burst_time,
  input  logic                        in_last_job,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [nps_pkg::JOB_W-1:0]   out_job_number,
  output logic [nps_pkg::TIME_W-1:0]  out_completion_time,
  output logic [nps_pkg::TIME_W-1:0]  out_turnaround_time,
  output logic [nps_pkg::TIME_W-1:0]  out_waiting_time,
  output logic                        out_last_result
);
  import nps_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  nps_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_last_job (in_last_job),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  nps_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_arrival_time     (in_arrival_time),
    .in_priority_req     (in_priority_req),
    .in_burst_time       (in_burst_time),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_job_number      (out_job_number),
    .out_completion_time (out_completion_time),
    .out_turnaround_time (out_turnaround_time),
    .out_waiting_time    (out_waiting_time),
    .out_last_result     (out_last_result)
  );

endmodule

### test/nonpreemptive_priority_scheduler_top_tb.sv
// Self-checking testbench for the non-preemptive priority scheduler top level.
`timescale 1ns / 1ps

module nonpreemptive_priority_scheduler_top_tb;
  import nps_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_JOBS  = 140;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_LIMIT = 40;

  typedef struct packed {
    logic [JOB_W-1:0]  job_number;
    logic [TIME_W-1:0] completion;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              last_result;
  } completion_t;

  typedef struct {
    logic [ARR_W-1:0] arrival;
    logic [PRI_W-1:0] prio;
    logic [BUR_W-1:0] burst;
    logic             last_job;
    bit               typed;
    completion_t      known;
  } job_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ARR_W-1:0] in_arrival_time = '0;
  logic [PRI_W-1:0] in_priority_req = '0;
  logic [BUR_W-1:0] in_burst_time = '0;
  logic in_last_job = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [JOB_W-1:0] out_job_number;
  logic [TIME_W-1:0] out_completion_time;
  logic [TIME_W-1:0] out_turnaround_time;
  logic [TIME_W-1:0] out_waiting_time;
  logic out_last_result;

  // scheduler mirror
  logic [ARR_W-1:0] job_arrival [MAX_PROCS];
  logic [PRI_W-1:0] job_priority [MAX_PROCS];
  logic [BUR_W-1:0] job_burst [MAX_PROCS];
  int jobs_held = 0;
  logic [TIME_W-1:0] sched_clock = '0;

  completion_t expected_completions [$];
  job_row_t directed_jobs [$];

  int error_count = 0;
  int cycle_count = 0;
  int jobs_sent = 0;
  int jobs_dropped = 0;
  int sets_closed = 0;
  int completions_checked = 0;
  int holds_asked = 0;
  int holds_seen = 0;
  int hold_left = 0;
  bit calm = 1'b0;

  nonpreemptive_priority_scheduler_top uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_arrival_time     (in_arrival_time),
    .in_priority_req     (in_priority_req),
    .in_burst_time       (in_burst_time),
    .in_last_job         (in_last_job),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_job_number      (out_job_number),
    .out_completion_time (out_completion_time),
    .out_turnaround_time (out_turnaround_time),
    .out_waiting_time    (out_waiting_time),
    .out_last_result     (out_last_result)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d completions outstanding", cycle_count,
               expected_completions.size());
      $display("nonpreemptive_priority_scheduler_top_tb: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  function automatic bit runs_first(input int a, input int b);
    if (job_priority[a] != job_priority[b]) return job_priority[a] > job_priority[b];
    if (job_arrival[a] != job_arrival[b]) return job_arrival[a] < job_arrival[b];
    return a < b;
  endfunction

  function automatic void schedule_held_jobs();
    bit finished [MAX_PROCS];
    int pick;
    int unsigned next_arrival;
    int unsigned earliest;
    completion_t c;
    logic [TIME_W-1:0] tat;
    foreach (finished[i]) finished[i] = 1'b0;
    earliest = 32'hFFFF_FFFF;
    for (int i = 0; i < jobs_held; i++)
      if (job_arrival[i] < earliest) earliest = job_arrival[i];
    sched_clock = TIME_W'(earliest);
    for (int k = 0; k < jobs_held; k++) begin
      pick = -1;
      next_arrival = 32'hFFFF_FFFF;
      for (int i = 0; i < jobs_held; i++) begin
        if (finished[i]) continue;
        if (job_arrival[i] < next_arrival) next_arrival = job_arrival[i];
        if (TIME_W'(job_arrival[i]) <= sched_clock && (pick < 0 || runs_first(i, pick)))
          pick = i;
      end
      if (pick < 0) begin
        sched_clock = TIME_W'(next_arrival);
        for (int i = 0; i < jobs_held; i++)
          if (!finished[i] && TIME_W'(job_arrival[i]) <= sched_clock &&
              (pick < 0 || runs_first(i, pick)))
            pick = i;
      end
      sched_clock = sched_clock + TIME_W'(job_burst[pick]);
      tat = sched_clock - TIME_W'(job_arrival[pick]);
      finished[pick] = 1'b1;
      c.job_number = JOB_W'(pick + 1);
      c.completion = sched_clock;
      c.turnaround = tat;
      c.waiting = tat - TIME_W'(job_burst[pick]);
      c.last_result = (k + 1 == jobs_held);
      expected_completions.push_back(c);
    end
    jobs_held = 0;
    sets_closed++;
  endfunction

  function automatic void take_job(input logic [ARR_W-1:0] arr, input logic [PRI_W-1:0] pri,
                                   input logic [BUR_W-1:0] bur, input logic last);
    if (jobs_held < MAX_PROCS) begin
      job_arrival[jobs_held] = arr;
      job_priority[jobs_held] = pri;
      job_burst[jobs_held] = bur;
      jobs_held++;
    end else begin
      jobs_dropped++;
    end
    if (last) schedule_held_jobs();
  endfunction

  task automatic send_job(input logic [ARR_W-1:0] arr, input logic [PRI_W-1:0] pri,
                          input logic [BUR_W-1:0] bur, input logic last);
    in_valid <= 1'b1;
    in_arrival_time <= arr;
    in_priority_req <= pri;
    in_burst_time <= bur;
    in_last_job <= last;
    do @(posedge clk); while (in_stall);
    take_job(arr, pri, bur, last);
    jobs_sent++;
  endtask

  task automatic maybe_idle();
    if (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_completions.size() != 0) @(posedge clk);
  endtask

  function automatic void add_row(input logic [ARR_W-1:0] arr, input logic [PRI_W-1:0] pri,
                                  input logic [BUR_W-1:0] bur, input logic last,
                                  input bit typed, input completion_t known);
    job_row_t row;
    row.arrival = arr;
    row.prio = pri;
    row.burst = bur;
    row.last_job = last;
    row.typed = typed;
    row.known = known;
    directed_jobs.push_back(row);
  endfunction

  task automatic check_completion();
    completion_t got;
    completion_t want;
    got = '{out_job_number, out_completion_time, out_turnaround_time, out_waiting_time,
            out_last_result};
    if (expected_completions.size() == 0) begin
      report_mismatch($sformatf("unexpected completion of job %0d", got.job_number));
      return;
    end
    want = expected_completions.pop_front();
    completions_checked++;
    if (got.job_number != want.job_number)
      report_mismatch($sformatf("job number %0d, want %0d", got.job_number, want.job_number));
    if (got.completion != want.completion)
      report_mismatch($sformatf("job %0d completion %0d, want %0d", want.job_number,
                                got.completion, want.completion));
    if (got.turnaround != want.turnaround)
      report_mismatch($sformatf("job %0d turnaround %0d, want %0d", want.job_number,
                                got.turnaround, want.turnaround));
    if (got.waiting != want.waiting)
      report_mismatch($sformatf("job %0d waiting %0d, want %0d", want.job_number,
                                got.waiting, want.waiting));
    if (got.last_result != want.last_result)
      report_mismatch($sformatf("job %0d last flag %0b, want %0b", want.job_number,
                                got.last_result, want.last_result));
  endtask

  // result side: check, then hold off or stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_completion();
      if (holds_seen != holds_asked) begin
        holds_seen = holds_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 19);
      end
    end
  end

  initial begin
    int set_size;
    int set_no;
    int pick_size;
    bit tie_heavy;
    logic [ARR_W-1:0] base;
    logic [ARR_W-1:0] arr;
    logic [PRI_W-1:0] pri;
    logic [BUR_W-1:0] bur;

    add_row(16'd0, 8'd0, 16'd0, 1'b1, 1'b1, '{5'd1, 21'd0, 21'd0, 21'd0, 1'b1});
    add_row(16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1,
            '{5'd1, 21'd131070, 21'd65535, 21'd0, 1'b1});
    // ties on position, zero burst and idle gaps
    add_row(16'd100, 8'd5, 16'd0, 1'b0, 1'b0, '0);
    add_row(16'd100, 8'd5, 16'd20, 1'b0, 1'b0, '0);
    add_row(16'd50, 8'd2, 16'd30, 1'b0, 1'b0, '0);
    add_row(16'd500, 8'd9, 16'd5, 1'b1, 1'b0, '0);
    // full store, then one job dropped plain and one dropped closing the set
    for (int i = 0; i < MAX_PROCS; i++)
      add_row(ARR_W'((i % 5) * 10), PRI_W'(i % 3), BUR_W'((i * 7) % 11), 1'b0, 1'b0, '0);
    add_row(16'hFFFF, 8'hFF, 16'hFFFF, 1'b0, 1'b0, '0);
    add_row(16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_jobs[i]) begin
      send_job(directed_jobs[i].arrival, directed_jobs[i].prio, directed_jobs[i].burst,
               directed_jobs[i].last_job);
      if (directed_jobs[i].typed)
        expected_completions[expected_completions.size() - 1] = directed_jobs[i].known;
      maybe_idle();
    end

    set_no = 0;
    while (jobs_sent < directed_jobs.size() + RANDOM_JOBS) begin
      pick_size = $urandom_range(99);
      if (pick_size < 65) set_size = $urandom_range(5, 1);
      else if (pick_size < 90) set_size = $urandom_range(MAX_PROCS, 6);
      else set_size = $urandom_range(MAX_PROCS + 3, MAX_PROCS + 1);
      tie_heavy = ($urandom_range(1) == 1);
      base = ARR_W'($urandom_range(16'hFFFF - 64));
      calm = (set_no >= 8 && set_no < 14);
      if (set_no == 3) holds_asked++;
      if (set_no == 5 || $urandom_range(9) == 0) wait_for_drain();
      for (int j = 0; j < set_size; j++) begin
        if (tie_heavy) begin
          arr = base + ARR_W'($urandom_range(40));
          pri = ($urandom_range(4) == 0) ? 8'hFF : PRI_W'($urandom_range(3));
          bur = BUR_W'($urandom_range(50));
        end else begin
          arr = ARR_W'($urandom);
          pri = PRI_W'($urandom);
          bur = BUR_W'($urandom);
        end
        send_job(arr, pri, bur, j == set_size - 1);
        maybe_idle();
      end
      set_no++;
    end

    calm = 1'b0;
    wait_for_drain();
    repeat (SETTLE_LIMIT) @(posedge clk);
    $display("covered %0d jobs in %0d sets, %0d dropped on a full store", jobs_sent,
             sets_closed, jobs_dropped);
    $display("checked %0d completions with random stalls, one long hold-off and drains",
             completions_checked);
    if (error_count == 0) begin
      $display("nonpreemptive_priority_scheduler_top_tb: clean");
    end else begin
      $display("nonpreemptive_priority_scheduler_top_tb: errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/nps_pkg.sv
src/nps_ctrl.sv
src/nps_datapath.sv
src/nonpreemptive_priority_scheduler_top.sv
test/nonpreemptive_priority_scheduler_top_tb.sv
